>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define DEQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// The condition must never be true outside reset.
`define DEQ_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition: label");

`else

`define DEQ_ASSERT(label, clk, rst, prop)
`define DEQ_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

>>> rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Request and status codes, controller states and the command and status
// bundles shared between the deque controller and datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [REQ_TUSER_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } req_op_type;

   typedef enum logic [RSP_TUSER_W-1:0] {
      RSP_OK    = 2'd0,
      RSP_EMPTY = 2'd1,
      RSP_FULL  = 2'd2
   } rsp_status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_LOAD = 1'b1
   } deq_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           exec;      // request taken this cycle
      logic           do_op;     // request is carried out (not refused)
      req_op_type     op;        // request code as received
      rsp_status_type status;    // status of this request
      logic           load_rsp;  // move pending result to the output register
   } deq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
   } deq_stat_type;

endpackage

>>> rtl/core/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Deque controller
// Takes one request at a time, decides its status and sequences the result
// into the output register.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [2:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  deq_pkg::deq_stat_type stat,
   output deq_pkg::deq_cmd_type  cmd
);
   import deq_pkg::*;

   deq_state_type state_ff;
   deq_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   req_op_type    op;
   logic          is_push;
   logic          is_read;

   assign op = req_op_type'(req_tuser);

   always_comb begin
      is_push = 1'b0;
      is_read = 1'b0;
      unique case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            is_push = 1'b1;
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            is_read = 1'b1;
         end
         default: begin
            // Unknown codes are answered with ok and leave the queue alone.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               cmd.op   = op;
               priority if (is_push && stat.full) begin
                  cmd.status = RSP_FULL;
               end else if (is_read && stat.empty) begin
                  cmd.status = RSP_EMPTY;
               end else begin
                  cmd.status = RSP_OK;
                  cmd.do_op  = 1'b1;
               end
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/core/deq_dpath.sv
// ----------------------------------------------------------------------------
// Deque datapath
// Slot memory, head index, entry count, pending result and output register.
// ----------------------------------------------------------------------------
module deq_dpath #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 32,
   parameter int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int CNT_W  = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [DATA_W-1:0]     push_data,
   input  deq_pkg::deq_cmd_type  cmd,
   output deq_pkg::deq_stat_type stat,
   output logic [1:0]            rsp_status,
   output logic [DATA_W-1:0]     rsp_data,
   output logic [CNT_W-1:0]      rsp_count
);
   import deq_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   logic [DATA_W-1:0] slot_mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;
   logic [IDX_W-1:0]  head_ff;
   logic [IDX_W-1:0]  head_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   rsp_status_type    pend_status_ff;
   logic              pend_zero_ff;
   logic              pend_zero_in;
   logic [1:0]        out_status_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic [CNT_W-1:0]  out_count_ff;

   logic [IDX_W-1:0]  head_m1;
   logic [IDX_W-1:0]  head_p1;
   logic [SUM_W-1:0]  tail_sum;
   logic [SUM_W-1:0]  last_sum;
   logic [IDX_W-1:0]  tail_slot;
   logic [IDX_W-1:0]  last_slot;
   logic [IDX_W-1:0]  waddr;
   logic [IDX_W-1:0]  raddr;
   logic              wen;
   logic              ren;

   // Neighbors of the head and the two back positions, wrapped by one
   // compare and subtract since every sum stays below twice the depth.
   assign head_m1 = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_p1 = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign last_sum = tail_sum - 1'b1;

   assign tail_slot = (tail_sum >= SUM_W'(DEPTH)) ?
                      IDX_W'(tail_sum - SUM_W'(DEPTH)) : IDX_W'(tail_sum);
   assign last_slot = (last_sum >= SUM_W'(DEPTH)) ?
                      IDX_W'(last_sum - SUM_W'(DEPTH)) : IDX_W'(last_sum);

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      waddr        = head_m1;
      raddr        = head_ff;
      wen          = 1'b0;
      ren          = 1'b0;
      pend_zero_in = 1'b1;
      if (cmd.exec && cmd.do_op) begin
         unique case (cmd.op)
            OP_PUSH_FRONT: begin
               wen      = 1'b1;
               waddr    = head_m1;
               head_in  = head_m1;
               count_in = count_ff + 1'b1;
            end
            OP_PUSH_BACK: begin
               wen      = 1'b1;
               waddr    = tail_slot;
               count_in = count_ff + 1'b1;
            end
            OP_POP_FRONT: begin
               ren          = 1'b1;
               raddr        = head_ff;
               pend_zero_in = 1'b0;
               head_in      = head_p1;
               count_in     = count_ff - 1'b1;
            end
            OP_POP_BACK: begin
               ren          = 1'b1;
               raddr        = last_slot;
               pend_zero_in = 1'b0;
               count_in     = count_ff - 1'b1;
            end
            OP_PEEK_FRONT: begin
               ren          = 1'b1;
               raddr        = head_ff;
               pend_zero_in = 1'b0;
            end
            OP_PEEK_BACK: begin
               ren          = 1'b1;
               raddr        = last_slot;
               pend_zero_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         slot_mem_ff[waddr] <= push_data;
      end
      if (ren) begin
         rdata_ff <= slot_mem_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         pend_status_ff <= cmd.status;
         pend_zero_ff   <= pend_zero_in;
      end
      if (cmd.load_rsp) begin
         out_status_ff <= pend_status_ff;
         out_data_ff   <= pend_zero_ff ? '0 : rdata_ff;
         out_count_ff  <= count_ff;
      end
   end

   assign rsp_status = out_status_ff;
   assign rsp_data   = out_data_ff;
   assign rsp_count  = out_count_ff;

endmodule

>>> rtl/core/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of DATA_W-bit words in a circular slot memory, with push,
// pop and peek at either end and a status and entry count per request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  tdata (low bit up)               tuser
//   req_      in         push_data                        req_type
//   rsp_      out        read_data, entry_count           status
//
// In the accept cycle a request reads or writes the slot memory through its
// single port and updates head and count; the load state that follows then
// moves the result into the output register.
// The core takes the next request while a finished response still waits in
// the output register; it holds in its load state only when a second result
// is ready before the first one has been taken.
// reset is synchronous and active high; it empties the queue and drops any
// pending response. The slot memory is not cleared, and no slot is read
// before it has been written.
//
module double_ended_queue_core #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [DATA_W-1:0] push_data, zero padded to whole bytes.
   input  logic [((DATA_W + 7) / 8) * 8 - 1:0]    req_tdata,
   // [2:0] req_type.
   input  logic [deq_pkg::REQ_TUSER_W-1:0]        req_tuser,
   // Response channel.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [DATA_W-1:0] read_data, then entry_count, zero padded to whole bytes.
   output logic [((DATA_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // [1:0] status.
   output logic [deq_pkg::RSP_TUSER_W-1:0]        rsp_tuser
);
   import deq_pkg::*;

   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int RSP_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

   deq_cmd_type       cmd;
   deq_stat_type      stat;
   logic [1:0]        rsp_status;
   logic [DATA_W-1:0] rsp_data;
   logic [CNT_W-1:0]  rsp_count;
   logic              cmd_is_push;

   // The controller owns the handshakes and decides each request's status.
   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the slots, the head and count, and the result.
   deq_dpath #(
      .DEPTH  (DEPTH),
      .DATA_W (DATA_W),
      .IDX_W  (IDX_W),
      .CNT_W  (CNT_W)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .push_data  (req_tdata[DATA_W-1:0]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = RSP_TDATA_W'({rsp_count, rsp_data});
   assign rsp_tuser = rsp_status;

   assign cmd_is_push = (cmd.op == OP_PUSH_FRONT) || (cmd.op == OP_PUSH_BACK);

`include "assert_macros.svh"

   // A full queue that is also empty means the count went out of range.
   `DEQ_ASSERT_NEVER(a_full_and_empty, clock, reset, stat.full && stat.empty)

   // Only a push is ever refused because the queue is full.
   `DEQ_ASSERT(a_full_only_push, clock, reset, (cmd.exec && cmd.status == RSP_FULL) |-> cmd_is_push)

   // Loading the output register always presents a response next cycle.
   `DEQ_ASSERT(a_load_shows_rsp, clock, reset, cmd.load_rsp |=> rsp_tvalid)

   // A reported count never exceeds the depth.
   `DEQ_ASSERT(a_count_in_range, clock, reset, rsp_tvalid |-> (rsp_count <= CNT_W'(DEPTH)))

endmodule

>>> tb/deq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque response checker
// Watches both stream channels of the deque core, keeps its own copy of the
// queue contents, predicts the response to every accepted request and
// compares each accepted response against the oldest prediction.
// ----------------------------------------------------------------------------
module deq_checker #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   input  logic                                          req_tready,
   input  logic [((DATA_W + 7) / 8) * 8 - 1:0]           req_tdata,
   input  logic [deq_pkg::REQ_TUSER_W-1:0]               req_tuser,
   input  logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   input  logic [((DATA_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic [deq_pkg::RSP_TUSER_W-1:0]               rsp_tuser,
   output int                                            mismatches,
   output int                                            outstanding
);
   import deq_pkg::*;

   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      rsp_status_type      status;
      logic [DATA_W-1:0]   word;
      logic [COUNT_W-1:0]  count;
   } deq_result_type;

   logic [DATA_W-1:0] slot_copy [DEPTH];
   int                front_slot;
   int                fill_level;
   deq_result_type    pending_results [$];
   int                bad_fields = 0;

   assign mismatches = bad_fields;

   // Applies one request to the shadow queue and returns its response.
   function automatic deq_result_type apply_request(logic [REQ_TUSER_W-1:0] op,
                                                    logic [DATA_W-1:0] word);
      deq_result_type res;
      int             slot;
      res.status = RSP_OK;
      res.word   = '0;
      if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && fill_level >= DEPTH) begin
         res.status = RSP_FULL;
      end else if (op >= OP_POP_FRONT && op <= OP_PEEK_BACK && fill_level == 0) begin
         res.status = RSP_EMPTY;
      end else begin
         case (op)
            OP_PUSH_FRONT: begin
               front_slot = (front_slot + DEPTH - 1) % DEPTH;
               slot_copy[front_slot] = word;
               fill_level++;
            end
            OP_PUSH_BACK: begin
               slot = (front_slot + fill_level) % DEPTH;
               slot_copy[slot] = word;
               fill_level++;
            end
            OP_POP_FRONT: begin
               res.word = slot_copy[front_slot];
               front_slot = (front_slot + 1) % DEPTH;
               fill_level--;
            end
            OP_POP_BACK: begin
               slot = (front_slot + fill_level - 1) % DEPTH;
               res.word = slot_copy[slot];
               fill_level--;
            end
            OP_PEEK_FRONT: begin
               res.word = slot_copy[front_slot];
            end
            OP_PEEK_BACK: begin
               slot = (front_slot + fill_level - 1) % DEPTH;
               res.word = slot_copy[slot];
            end
            default: begin
               // Unknown codes leave the queue alone.
            end
         endcase
      end
      res.count = COUNT_W'(fill_level);
      return res;
   endfunction

   always @(posedge clock) begin
      deq_result_type     want;
      logic [COUNT_W-1:0] got_count;
      if (reset) begin
         pending_results.delete();
         front_slot = 0;
         fill_level = 0;
         outstanding <= 0;
      end else begin
         // The response at this edge always belongs to an older request.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("response with no request waiting: status %0d", rsp_tuser);
               bad_fields++;
            end else begin
               want = pending_results.pop_front();
               got_count = rsp_tdata[DATA_W +: COUNT_W];
               if (rsp_tuser !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_tuser);
                  bad_fields++;
               end
               if (rsp_tdata[DATA_W-1:0] !== want.word) begin
                  $error("read_data mismatch: expected %h, actual %h", want.word,
                         rsp_tdata[DATA_W-1:0]);
                  bad_fields++;
               end
               if (got_count !== want.count) begin
                  $error("entry_count mismatch: expected %0d, actual %0d", want.count,
                         got_count);
                  bad_fields++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_results.push_back(apply_request(req_tuser, req_tdata[DATA_W-1:0]));
         end
         outstanding <= pending_results.size();
      end
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque core testbench
// Drives request streams into the deque core under varying sender and
// receiver idling, and lets the checker predict and compare every response.
// ----------------------------------------------------------------------------
module tb_top;
   import deq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int REQ_DATA_W  = ((DATA_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((DATA_W + COUNT_W + 7) / 8) * 8;
   localparam int PHASE_ITEMS = 335;
   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 200000;

   // The request code field is three bits wide, and the two codes above the
   // defined set must be ignored by the core.
   localparam logic [REQ_TUSER_W-1:0] OP_UNKNOWN_LO = 3'd6;
   localparam logic [REQ_TUSER_W-1:0] OP_UNKNOWN_HI = 3'd7;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;     // [31:0] push_data
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;     // [2:0] req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;           // [31:0] read_data, [36:32] entry_count
   logic [RSP_TUSER_W-1:0] rsp_tuser;           // [1:0] status

   int mismatches;
   int outstanding;
   int cycle_count  = 0;
   int stall_pct    = 0;
   int hold_request = 0;
   int hold_served  = 0;
   int hold_left    = 0;

   always #4 clock = ~clock;

   double_ended_queue_core #(
      .DEPTH  (DEPTH),
      .DATA_W (DATA_W)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   deq_checker #(
      .DEPTH  (DEPTH),
      .DATA_W (DATA_W)
   ) checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Receiver side. A bump of hold_request starts one long hold-off during
   // which the core has to fill up and push back on the request channel.
   // Otherwise the receiver stalls at random at the current phase's rate.
   always @(posedge clock) begin
      if (hold_request != hold_served) begin
         hold_served <= hold_request;
         hold_left   <= LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Presents one request and returns at the edge where it is accepted.
   // The valid line is left high, so a following request goes out
   // back to back unless a gap is inserted.
   task automatic offer_request(logic [REQ_TUSER_W-1:0] op, logic [DATA_W-1:0] word);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'(word);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Random gap after a request; each extra idle cycle has the given odds.
   task automatic idle_sender(int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stops sending and waits for every predicted response. The first edge
   // is needed because the checker's count is registered and lags the bus.
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Picks a push word: mostly random, sometimes all zeros or all ones.
   function automatic logic [DATA_W-1:0] pick_word();
      int roll;
      roll = $urandom_range(19);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return DATA_W'($urandom());
   endfunction

   // Random traffic. The push bias is redrawn every few dozen requests so
   // the fill level swings between empty and full instead of hovering in
   // the middle. A few requests carry unknown codes.
   task automatic random_traffic(int n_items, int idle_pct);
      int                     push_pct;
      int                     roll;
      logic [REQ_TUSER_W-1:0] op;
      push_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % 30 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 85;
               1: push_pct = 50;
               default: push_pct = 15;
            endcase
         end
         roll = $urandom_range(99);
         if (roll < 4) begin
            op = $urandom_range(1) ? OP_UNKNOWN_HI : OP_UNKNOWN_LO;
         end else if ($urandom_range(99) < push_pct) begin
            op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         end else begin
            case ($urandom_range(3))
               0: op = OP_POP_FRONT;
               1: op = OP_POP_BACK;
               2: op = OP_PEEK_FRONT;
               default: op = OP_PEEK_BACK;
            endcase
         end
         offer_request(op, pick_word());
         idle_sender(idle_pct);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Refusals on an empty queue, an unknown code, both
      // data extremes, peeks at both ends, and a pop that takes the last
      // entry so both ends go empty together.
      offer_request(OP_POP_FRONT, '1);
      offer_request(OP_PEEK_BACK, '0);
      offer_request(OP_UNKNOWN_LO, '1);
      offer_request(OP_PUSH_FRONT, '0);
      offer_request(OP_PUSH_BACK, '1);
      offer_request(OP_PEEK_FRONT, '0);
      offer_request(OP_PEEK_BACK, '0);
      offer_request(OP_POP_BACK, '0);
      offer_request(OP_POP_FRONT, '0);
      // Fill the queue from both ends with walking-bit patterns, then try
      // to overfill it from either side.
      for (int i = 0; i < DEPTH; i++) begin
         offer_request((i % 2 != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                       (i % 2 != 0) ? ~(DATA_W'(1) << i) : (DATA_W'(1) << i));
      end
      offer_request(OP_PUSH_BACK, '1);
      offer_request(OP_PUSH_FRONT, '1);
      offer_request(OP_UNKNOWN_HI, '0);
      offer_request(OP_PEEK_BACK, '0);
      wait_for_responses();

      // Phase with no idling on either side.
      random_traffic(PHASE_ITEMS, 0);

      // Back pressure: drain first, then hold the receiver off for a long
      // stretch while requests keep coming, so the core fills and stalls.
      wait_for_responses();
      hold_request <= hold_request + 1;
      random_traffic(40, 0);
      wait_for_responses();

      // Sender idles often, receiver always ready.
      random_traffic(PHASE_ITEMS, 58);
      wait_for_responses();

      // Receiver stalls often, sender back to back.
      stall_pct <= 58;
      random_traffic(PHASE_ITEMS, 0);
      wait_for_responses();

      // Both sides idle.
      stall_pct <= 34;
      random_traffic(PHASE_ITEMS, 34);
      wait_for_responses();

      // Quiet tail: nothing should come out after the last response.
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
